// ===== rtl/tksd_pkg.sv =====
// Shared types, constants and key decoding functions of the key sequence decoder.
`default_nettype none

package tksd_pkg;

    // Byte values that the decoder recognizes.
    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] DEL_BYTE      = 8'h7F;
    localparam logic [7:0] BS_BYTE       = 8'h08;
    localparam logic [7:0] TAB_BYTE      = 8'h09;
    localparam logic [7:0] LF_BYTE       = 8'h0A;
    localparam logic [7:0] CR_BYTE       = 8'h0D;
    localparam logic [7:0] TILDE_BYTE    = 8'h7E;
    localparam logic [7:0] LBRACKET_BYTE = 8'h5B;
    localparam logic [7:0] CHAR_O        = 8'h4F;
    localparam logic [7:0] CHAR_M        = 8'h4D;
    localparam logic [7:0] CHAR_A        = 8'h41;
    localparam logic [7:0] CHAR_B        = 8'h42;
    localparam logic [7:0] CHAR_C        = 8'h43;
    localparam logic [7:0] CHAR_D        = 8'h44;
    localparam logic [7:0] CHAR_H        = 8'h48;
    localparam logic [7:0] CHAR_F        = 8'h46;
    localparam logic [7:0] CHAR_P        = 8'h50;
    localparam logic [7:0] CHAR_Q        = 8'h51;
    localparam logic [7:0] CHAR_R        = 8'h52;
    localparam logic [7:0] CHAR_S        = 8'h53;
    localparam logic [7:0] DIGIT_0       = 8'h30;
    localparam logic [7:0] DIGIT_9       = 8'h39;

    // Decimal parameter tracking.
    localparam logic [1:0] NUM_RUNNING = 2'd0;
    localparam logic [1:0] NUM_DONE    = 2'd1;
    localparam logic [1:0] NUM_BAD     = 2'd2;
    localparam logic [6:0] NUM_MAX     = 7'd99;
    localparam logic [2:0] POS_MAX     = 3'd7;

    // Dense key codes.
    localparam logic [4:0] KC_ESC   = 5'd0;
    localparam logic [4:0] KC_UP    = 5'd1;
    localparam logic [4:0] KC_DOWN  = 5'd2;
    localparam logic [4:0] KC_RIGHT = 5'd3;
    localparam logic [4:0] KC_LEFT  = 5'd4;
    localparam logic [4:0] KC_HOME  = 5'd5;
    localparam logic [4:0] KC_END   = 5'd6;
    localparam logic [4:0] KC_INS   = 5'd7;
    localparam logic [4:0] KC_DEL   = 5'd8;
    localparam logic [4:0] KC_PGUP  = 5'd9;
    localparam logic [4:0] KC_PGDN  = 5'd10;
    localparam logic [4:0] KC_F1    = 5'd11;
    localparam logic [4:0] KC_F2    = 5'd12;
    localparam logic [4:0] KC_F3    = 5'd13;
    localparam logic [4:0] KC_F4    = 5'd14;
    localparam logic [4:0] KC_F5    = 5'd15;
    localparam logic [4:0] KC_F6    = 5'd16;
    localparam logic [4:0] KC_F7    = 5'd17;
    localparam logic [4:0] KC_F8    = 5'd18;
    localparam logic [4:0] KC_F9    = 5'd19;
    localparam logic [4:0] KC_F10   = 5'd20;
    localparam logic [4:0] KC_F11   = 5'd21;
    localparam logic [4:0] KC_F12   = 5'd22;
    localparam logic [4:0] KC_TAB   = 5'd23;
    localparam logic [4:0] KC_ENTER = 5'd24;
    localparam logic [4:0] KC_BKSP  = 5'd25;

    // Depth of the queue between the byte collector and the key decoder.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] seq_byte;
        logic       seq_end;
    } seq_in_t;

    typedef struct packed {
        logic       is_special;
        logic [4:0] key_id;
        logic [7:0] char_code;
    } key_out_t;

    // Everything collected from one finished sequence.
    typedef struct packed {
        logic [2:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [6:0] number_value;
        logic [1:0] number_status;
    } seq_rec_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= DIGIT_0) && (b <= DIGIT_9);
    endfunction

    function automatic logic [4:0] arrow_key(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            CHAR_A:  k = KC_UP;
            CHAR_B:  k = KC_DOWN;
            CHAR_C:  k = KC_RIGHT;
            CHAR_D:  k = KC_LEFT;
            CHAR_H:  k = KC_HOME;
            CHAR_F:  k = KC_END;
            default: k = KC_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] letter_key(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            CHAR_P:  k = KC_F1;
            CHAR_Q:  k = KC_F2;
            CHAR_R:  k = KC_F3;
            CHAR_S:  k = KC_F4;
            default: k = arrow_key(b);
        endcase
        return k;
    endfunction

    // Map of the decimal parameter of ESC [ n ~ to a key.
    function automatic logic [4:0] number_key(input logic [6:0] n);
        logic [4:0] k;
        unique case (n)
            7'd1:    k = KC_HOME;
            7'd2:    k = KC_INS;
            7'd3:    k = KC_DEL;
            7'd4:    k = KC_END;
            7'd5:    k = KC_PGUP;
            7'd6:    k = KC_PGDN;
            7'd7:    k = KC_HOME;
            7'd8:    k = KC_END;
            7'd11:   k = KC_F1;
            7'd12:   k = KC_F2;
            7'd13:   k = KC_F3;
            7'd14:   k = KC_F4;
            7'd15:   k = KC_F5;
            7'd17:   k = KC_F6;
            7'd18:   k = KC_F7;
            7'd19:   k = KC_F8;
            7'd20:   k = KC_F9;
            7'd21:   k = KC_F10;
            7'd23:   k = KC_F11;
            7'd24:   k = KC_F12;
            default: k = KC_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] decode_escape(input seq_rec_t r);
        logic [4:0] k;
        k = KC_ESC;
        priority if (r.byte_count < 3'd2) begin
            k = KC_ESC;
        end else if (r.second_byte == CHAR_O) begin
            k = (r.byte_count >= 3'd3) ? letter_key(r.third_byte) : KC_ESC;
        end else if (r.second_byte != LBRACKET_BYTE || r.byte_count < 3'd3) begin
            k = KC_ESC;
        end else if (arrow_key(r.third_byte) != KC_ESC) begin
            k = arrow_key(r.third_byte);
        end else if (r.third_byte == CHAR_M) begin
            if (r.byte_count >= 3'd4 && r.fourth_byte >= 8'd1 && r.fourth_byte <= 8'd12) begin
                k = KC_F1 + {1'b0, r.fourth_byte[3:0]} - 5'd1;
            end
        end else if (r.third_byte == CHAR_O) begin
            k = (r.byte_count >= 3'd4) ? letter_key(r.fourth_byte) : KC_ESC;
        end else if (is_digit(r.third_byte) && r.number_status != NUM_BAD) begin
            k = number_key(r.number_value);
        end else begin
            k = KC_ESC;
        end
        return k;
    endfunction

    function automatic key_out_t decode_key(input seq_rec_t r);
        key_out_t o;
        o.is_special = 1'b1;
        o.key_id     = KC_ESC;
        o.char_code  = 8'd0;
        priority if (r.first_byte == ESC_BYTE) begin
            o.key_id = decode_escape(r);
        end else if (r.first_byte == TAB_BYTE) begin
            o.key_id = KC_TAB;
        end else if (r.first_byte == LF_BYTE || r.first_byte == CR_BYTE) begin
            o.key_id = KC_ENTER;
        end else if (r.first_byte == DEL_BYTE || r.first_byte == BS_BYTE) begin
            o.key_id = KC_BKSP;
        end else begin
            o.is_special = 1'b0;
            o.char_code  = r.first_byte;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/terminal_key_sequence_decoder_core.sv =====
// Top level of the terminal key sequence decoder.
`default_nettype none

// The decoder takes the bytes of one key sequence, one request per byte, with
// seq_end set on the last byte, and returns one decoded key request per
// sequence. A byte is taken in every cycle while s_ready is high; s_ready
// drops only when the two-entry queue of finished sequences is full, which
// happens when the result side has stalled for a while. The collector stage
// keeps the first four bytes and the saturating decimal parameter of the
// sequence; when the last byte arrives it writes a snapshot into the queue.
// The decoder stage pops the queue into the output register as soon as that
// register is empty or being drained, so a key is registered first in the
// queue and then in the output register before m_valid rises, and one key per
// cycle can be delivered while m_ready stays high.
// Plain characters come out with is_special low and the byte in char_code;
// special keys carry the key code in key_id and a zero char_code.

module terminal_key_sequence_decoder_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tksd_pkg::seq_in_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tksd_pkg::key_out_t      m_data
);
    import tksd_pkg::*;

    // Handshake between the collector, the queue and the decoder.
    logic     q_push, q_pop, q_full, q_empty;
    seq_rec_t q_in, q_head;

    // Front: accepts bytes and builds the sequence snapshot.
    tksd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    // Queue: decouples byte intake from result delivery.
    tksd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: decodes the snapshot and presents the key.
    tksd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/tksd_front.sv =====
// Byte collector: gathers the bytes of a sequence and its decimal parameter.
`default_nettype none

module tksd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tksd_pkg::seq_in_t s_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output tksd_pkg::seq_rec_t     q_data
);
    import tksd_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic [7:0] b1_reg, b2_reg, b3_reg, b4_reg;
    logic [6:0] num_reg, num_next;
    logic [1:0] status_reg, status_next;
    logic       accept;
    logic [9:0] num_sum;
    logic [7:0] b;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.seq_byte;
    assign q_push  = accept && s_data.seq_end;

    always_comb begin
        num_sum     = ({3'b0, num_reg} << 3) + ({3'b0, num_reg} << 1)
                      + {6'b0, b[3:0]};
        num_next    = num_reg;
        status_next = status_reg;
        if (pos_reg >= 3'd2 && status_reg == NUM_RUNNING) begin
            priority if (b == TILDE_BYTE) begin
                status_next = NUM_DONE;
            end else if (is_digit(b)) begin
                num_next = (num_sum > {3'b0, NUM_MAX}) ? NUM_MAX : num_sum[6:0];
            end else begin
                status_next = NUM_BAD;
            end
        end
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 3'd1;

        q_data.byte_count    = pos_next;
        q_data.first_byte    = (pos_reg == 3'd0) ? b : b1_reg;
        q_data.second_byte   = (pos_reg == 3'd1) ? b : b2_reg;
        q_data.third_byte    = (pos_reg == 3'd2) ? b : b3_reg;
        q_data.fourth_byte   = (pos_reg == 3'd3) ? b : b4_reg;
        q_data.number_value  = num_next;
        q_data.number_status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 3'd0;
            num_reg    <= 7'd0;
            status_reg <= NUM_RUNNING;
        end else if (accept) begin
            if (s_data.seq_end) begin
                pos_reg    <= 3'd0;
                num_reg    <= 7'd0;
                status_reg <= NUM_RUNNING;
            end else begin
                pos_reg    <= pos_next;
                num_reg    <= num_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b1_reg <= q_data.first_byte;
            b2_reg <= q_data.second_byte;
            b3_reg <= q_data.third_byte;
            b4_reg <= q_data.fourth_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tksd_queue.sv =====
// Short queue of finished sequences between the collector and the decoder.
`default_nettype none

module tksd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire tksd_pkg::seq_rec_t push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output tksd_pkg::seq_rec_t      head
);
    import tksd_pkg::*;

    seq_rec_t                 entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic                     do_push, do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tksd_back.sv =====
// Key decoder: turns a finished sequence into a key and holds it in the output register.
`default_nettype none

module tksd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire tksd_pkg::seq_rec_t q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tksd_pkg::key_out_t      m_data
);
    import tksd_pkg::*;

    logic     m_valid_reg, m_valid_next;
    key_out_t m_data_reg;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= decode_key(q_head);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the terminal key sequence decoder core.
`default_nettype none

// Key sequences are driven into the decoder one byte per request. A scoreboard
// predicts the decoded key of every sequence on the request that carries its
// last byte, and checks each key request leaving the block against the oldest
// prediction. The run opens with hand-picked sequences: the byte extremes, the
// single control keys, the escape forms, a parameter ended by a stray letter,
// and a long parameter that saturates and is followed by ignored bytes. It then
// goes on with random sequences. Most of them are well-formed escape sequences
// with random content. The rest are plain bytes, broken forms and noise.
// Both sides pause in random bursts at a rate that changes now and then. The
// closing stretch runs at full speed.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tksd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_BYTES = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    // A key leaves the block after passing the queue and the output register; allow some slack.
    localparam int DRAIN_CYCLES = 10;

    // Predicts the key of each sequence and holds the keys still to come.
    class key_scoreboard;
        logic [2:0] taken;
        logic [7:0] head [4];
        logic [6:0] param_value;
        logic [1:0] param_state;
        key_out_t   expected_keys [$];
        int         errors;

        function new();
            errors = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            taken       = '0;
            param_value = '0;
            param_state = NUM_RUNNING;
            foreach (head[i]) head[i] = '0;
        endfunction

        function logic [4:0] cursor_key(logic [7:0] b);
            case (b)
                CHAR_A:  return KC_UP;
                CHAR_B:  return KC_DOWN;
                CHAR_C:  return KC_RIGHT;
                CHAR_D:  return KC_LEFT;
                CHAR_H:  return KC_HOME;
                CHAR_F:  return KC_END;
                default: return KC_ESC;
            endcase
        endfunction

        function logic [4:0] keypad_key(logic [7:0] b);
            case (b)
                CHAR_P:  return KC_F1;
                CHAR_Q:  return KC_F2;
                CHAR_R:  return KC_F3;
                CHAR_S:  return KC_F4;
                default: return cursor_key(b);
            endcase
        endfunction

        // Numbers of the ESC [ n ~ form.
        function logic [4:0] param_key(logic [6:0] n);
            case (n)
                7'd1, 7'd7: return KC_HOME;
                7'd2:       return KC_INS;
                7'd3:       return KC_DEL;
                7'd4, 7'd8: return KC_END;
                7'd5:       return KC_PGUP;
                7'd6:       return KC_PGDN;
                7'd11:      return KC_F1;
                7'd12:      return KC_F2;
                7'd13:      return KC_F3;
                7'd14:      return KC_F4;
                7'd15:      return KC_F5;
                7'd17:      return KC_F6;
                7'd18:      return KC_F7;
                7'd19:      return KC_F8;
                7'd20:      return KC_F9;
                7'd21:      return KC_F10;
                7'd23:      return KC_F11;
                7'd24:      return KC_F12;
                default:    return KC_ESC;
            endcase
        endfunction

        function logic [4:0] escape_key();
            if (taken < 3'd2) return KC_ESC;
            if (head[1] == CHAR_O) return (taken >= 3'd3) ? keypad_key(head[2]) : KC_ESC;
            if (head[1] != LBRACKET_BYTE || taken < 3'd3) return KC_ESC;
            if (cursor_key(head[2]) != KC_ESC) return cursor_key(head[2]);
            if (head[2] == CHAR_M) begin
                if (taken >= 3'd4 && head[3] >= 8'd1 && head[3] <= 8'd12) begin
                    return KC_F1 + head[3][4:0] - 5'd1;
                end
                return KC_ESC;
            end
            if (head[2] == CHAR_O) return (taken >= 3'd4) ? keypad_key(head[3]) : KC_ESC;
            if (head[2] >= DIGIT_0 && head[2] <= DIGIT_9 && param_state != NUM_BAD) begin
                return param_key(param_value);
            end
            return KC_ESC;
        endfunction

        function key_out_t decode_sequence();
            key_out_t k;
            k.is_special = 1'b1;
            k.key_id     = KC_ESC;
            k.char_code  = 8'd0;
            if (head[0] == ESC_BYTE) begin
                k.key_id = escape_key();
            end else if (head[0] == TAB_BYTE) begin
                k.key_id = KC_TAB;
            end else if (head[0] == LF_BYTE || head[0] == CR_BYTE) begin
                k.key_id = KC_ENTER;
            end else if (head[0] == DEL_BYTE || head[0] == BS_BYTE) begin
                k.key_id = KC_BKSP;
            end else begin
                k.is_special = 1'b0;
                k.char_code  = head[0];
            end
            return k;
        endfunction

        function void note_byte(seq_in_t req);
            int acc;
            if (taken < 3'd4) head[taken[1:0]] = req.seq_byte;
            // The decimal parameter is gathered from the third byte on.
            if (taken >= 3'd2 && param_state == NUM_RUNNING) begin
                if (req.seq_byte == TILDE_BYTE) begin
                    param_state = NUM_DONE;
                end else if (req.seq_byte >= DIGIT_0 && req.seq_byte <= DIGIT_9) begin
                    acc = int'(param_value) * 10 + int'(req.seq_byte - DIGIT_0);
                    param_value = (acc > int'(NUM_MAX)) ? NUM_MAX : 7'(acc);
                end else begin
                    param_state = NUM_BAD;
                end
            end
            if (taken != POS_MAX) taken = taken + 3'd1;
            if (req.seq_end) begin
                expected_keys.push_back(decode_sequence());
                clear_sequence();
            end
        endfunction

        function void check_key(key_out_t got);
            key_out_t want;
            if (expected_keys.size() == 0) begin
                $display("%0t: key request with none expected: special %0d id %0d char 0x%02h",
                         $time, got.is_special, got.key_id, got.char_code);
                errors++;
                return;
            end
            want = expected_keys.pop_front();
            if (got.is_special !== want.is_special) begin
                $display("%0t: is_special mismatch: expected %0d, actual %0d",
                         $time, want.is_special, got.is_special);
                errors++;
            end
            if (got.key_id !== want.key_id) begin
                $display("%0t: key_id mismatch: expected %0d, actual %0d",
                         $time, want.key_id, got.key_id);
                errors++;
            end
            if (got.char_code !== want.char_code) begin
                $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                         $time, want.char_code, got.char_code);
                errors++;
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    seq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    key_out_t m_data;

    key_scoreboard key_book;
    logic [7:0]    key_bytes [$];
    int            bytes_sent  = 0;
    int            cycle_count = 0;
    // Percentage of requests that are preceded by a pause, on either side.
    int            idle_pct    = 20;
    // Set for the closing stretch, where neither side pauses.
    logic          calm        = 1'b0;

    logic [7:0] keypad_letters [10] = '{CHAR_A, CHAR_B, CHAR_C, CHAR_D, CHAR_H, CHAR_F,
                                        CHAR_P, CHAR_Q, CHAR_R, CHAR_S};
    logic [7:0] control_bytes [5] = '{TAB_BYTE, LF_BYTE, CR_BYTE, DEL_BYTE, BS_BYTE};

    terminal_key_sequence_decoder_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Both handshakes are observed at the rising edge. Bytes are noted before
    // keys are checked, although a key never leaves in the cycle of its last byte.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) key_book.note_byte(s_data);
            if (m_valid && m_ready) key_book.check_key(m_data);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: ready drops in random bursts.
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Drives one byte request and returns at the edge that accepts it. Valid
    // stays high from one request to the next unless a pause falls between.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_data.seq_byte <= b;
        s_data.seq_end  <= last;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_key_bytes();
        foreach (key_bytes[i]) send_byte(key_bytes[i], i == key_bytes.size() - 1);
    endtask

    task automatic push_junk(input int count);
        repeat (count) key_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Fills key_bytes with one random sequence. Most are escape forms with
    // random content; some are cut short, carry trailing bytes or are noise.
    task automatic build_random_sequence();
        int    pick;
        int    n;
        string txt;
        key_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            key_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 20) begin
            key_bytes.push_back(control_bytes[$urandom_range(0, 4)]);
        end else if (pick < 25) begin
            // A plain or control first byte followed by bytes that do not matter.
            key_bytes.push_back((pick < 23) ? 8'($urandom_range(0, 255))
                                            : control_bytes[$urandom_range(0, 4)]);
            push_junk($urandom_range(1, 9));
        end else begin
            key_bytes.push_back(ESC_BYTE);
            if (pick < 30) begin
                if ($urandom_range(0, 1) == 0) push_junk($urandom_range(1, 3));
            end else if (pick < 42) begin
                key_bytes.push_back(LBRACKET_BYTE);
                key_bytes.push_back(keypad_letters[$urandom_range(0, 5)]);
            end else if (pick < 52) begin
                key_bytes.push_back(CHAR_O);
                if ($urandom_range(0, 7) != 0) begin
                    key_bytes.push_back(($urandom_range(0, 4) != 0)
                                        ? keypad_letters[$urandom_range(0, 9)]
                                        : 8'($urandom_range(0, 255)));
                end
            end else if (pick < 60) begin
                key_bytes.push_back(LBRACKET_BYTE);
                key_bytes.push_back(CHAR_O);
                if ($urandom_range(0, 7) != 0) begin
                    key_bytes.push_back(($urandom_range(0, 4) != 0)
                                        ? keypad_letters[$urandom_range(0, 9)]
                                        : 8'($urandom_range(0, 255)));
                end
            end else if (pick < 68) begin
                key_bytes.push_back(LBRACKET_BYTE);
                key_bytes.push_back(CHAR_M);
                if ($urandom_range(0, 7) != 0) begin
                    key_bytes.push_back(($urandom_range(0, 4) != 0)
                                        ? 8'($urandom_range(0, 13))
                                        : 8'($urandom_range(0, 255)));
                end
            end else if (pick < 90) begin
                // Decimal parameter: mostly table values, sometimes large ones.
                key_bytes.push_back(LBRACKET_BYTE);
                n = $urandom_range(0, 19);
                if (n < 12) begin
                    n = $urandom_range(1, 24);
                end else if (n < 17) begin
                    n = $urandom_range(0, 99);
                end else begin
                    n = $urandom_range(100, 99999);
                end
                if ($urandom_range(0, 7) == 0) key_bytes.push_back(DIGIT_0);
                if ($urandom_range(0, 15) != 0) begin
                    txt = $sformatf("%0d", n);
                    for (int i = 0; i < txt.len(); i++) key_bytes.push_back(8'(txt[i]));
                end
                if ($urandom_range(0, 7) == 0) push_junk(1);
                if ($urandom_range(0, 3) != 0) key_bytes.push_back(TILDE_BYTE);
            end else begin
                push_junk($urandom_range(1, 9));
            end
            if ($urandom_range(0, 4) == 0) push_junk($urandom_range(1, 5));
        end
    endtask

    initial begin
        key_book = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Byte extremes and the single-byte keys.
        key_bytes = '{8'h00};
        send_key_bytes();
        key_bytes = '{8'hFF};
        send_key_bytes();
        key_bytes = '{TAB_BYTE};
        send_key_bytes();
        key_bytes = '{CR_BYTE};
        send_key_bytes();
        key_bytes = '{DEL_BYTE};
        send_key_bytes();
        key_bytes = '{BS_BYTE};
        send_key_bytes();
        // ESC alone, a cursor key, and a keypad function key.
        key_bytes = '{ESC_BYTE};
        send_key_bytes();
        key_bytes = '{ESC_BYTE, LBRACKET_BYTE, CHAR_A};
        send_key_bytes();
        key_bytes = '{ESC_BYTE, CHAR_O, CHAR_P};
        send_key_bytes();
        // Insert, then the same parameter spoiled by a letter in place of the tilde.
        key_bytes = '{ESC_BYTE, LBRACKET_BYTE, 8'h32, TILDE_BYTE};
        send_key_bytes();
        key_bytes = '{ESC_BYTE, LBRACKET_BYTE, 8'h32, CHAR_A};
        send_key_bytes();
        // A saturating parameter in a sequence long enough to saturate the
        // byte count, with a byte after the tilde that must be ignored.
        key_bytes = '{ESC_BYTE, LBRACKET_BYTE, DIGIT_9, DIGIT_9, DIGIT_9, DIGIT_9,
                      TILDE_BYTE, CHAR_A};
        send_key_bytes();

        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 45;
                endcase
            end
            if (bytes_sent > RANDOM_BYTES * 17 / 20) calm = 1'b1;
            build_random_sequence();
            send_key_bytes();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (key_book.expected_keys.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (key_book.errors == 0 && key_book.expected_keys.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tksd_pkg.sv
rtl/tksd_front.sv
rtl/tksd_queue.sv
rtl/tksd_back.sv
rtl/terminal_key_sequence_decoder_core.sv
sim/tb_top.sv
